// ----- rtl/swmm_pkg.sv -----
// shared types and constants for the sliding window min/max block
package swmm_pkg;

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     first_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] window_max;
        logic signed [DATA_W-1:0] window_min;
    } t_out_req;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctl;

endpackage

// ----- rtl/swmm_cell.sv -----
// one storage cell of the sample chain: shifts in new samples or rotates toward the head
module swmm_cell
    import swmm_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_shift_data,
    input  logic signed [DATA_W-1:0] i_rot_data,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_shift_data;
        end else if (i_ctl.rotate) begin
            r_data <= i_rot_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/sliding_window_min_max.sv -----
// top level: sliding window minimum and maximum over a chain of sample cells
//
// Input channel i_in_valid / o_in_stall carries one sample request (value and
// first_sample flag). Output channel o_out_valid / i_out_stall carries the
// window maximum and minimum. The config channel i_cfg_valid / o_cfg_ready
// writes window_size; it is always ready. The user is to write window_size only
// while idle; the block itself does not enforce this. A sample is shifted into
// the head of a chain of WINDOW_MAX cells. When the window is full, the chain
// rotates once around and the head cell feeds a running max/min over the first
// window_size entries. An item that gives a result goes through S_SWEEP and
// S_DONE to the result register and blocks the input meanwhile; an item that
// gives no result leaves the block idle for the next sample. The rotation of
// the cell chain sets the length of S_SWEEP. The next sample is taken while a
// finished result still waits in the output register; a stalled receiver holds
// the result and, once a second result is ready, holds the chain and the input too.
// Reset clears the fill count, sets window_size to 1 and empties the output;
// store contents are not cleared.
module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_req         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CFG_W-1:0]         r_size;
    logic [CFG_W-1:0]         r_eff;
    logic [FW-1:0]            r_fill;
    logic [CW-1:0]            r_cnt;
    logic signed [DATA_W-1:0] r_hi;
    logic signed [DATA_W-1:0] r_lo;
    logic                     r_out_valid;
    t_out_req                 r_out_data;

    logic                     in_acc;
    logic [CFG_W-1:0]         n_eff;
    logic [FW-1:0]            n_fill;
    logic                     n_emit;
    t_cell_ctl                cell_ctl;
    logic signed [DATA_W-1:0] cell_data [WINDOW_MAX];
    logic signed [DATA_W-1:0] head;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign head        = cell_data[0];

    always_comb begin
        if (r_size == '0) begin
            n_eff = CFG_W'(1);
        end else if (32'(r_size) > 32'(WINDOW_MAX)) begin
            n_eff = CFG_W'(WINDOW_MAX);
        end else begin
            n_eff = r_size;
        end
        n_fill = i_in_data.first_sample ? '0 : r_fill;
        if (32'(n_fill) < 32'(WINDOW_MAX)) begin
            n_fill = n_fill + FW'(1);
        end
        n_emit = 32'(n_fill) >= 32'(n_eff);
    end

    assign cell_ctl.shift  = in_acc;
    assign cell_ctl.rotate = (r_state == S_SWEEP);

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic signed [DATA_W-1:0] shift_in;
        if (k == 0) begin : g_head
            assign shift_in = i_in_data.sample_value;
        end else begin : g_body
            assign shift_in = cell_data[k-1];
        end
        swmm_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_shift_data (shift_in),
            .i_rot_data   (cell_data[(k + 1) % WINDOW_MAX]),
            .o_data       (cell_data[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= CFG_W'(1);
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_fill <= n_fill;
                        r_eff  <= n_eff;
                        r_hi   <= i_in_data.sample_value;
                        r_lo   <= i_in_data.sample_value;
                        r_cnt  <= '0;
                        if (n_emit) begin
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP: begin
                    if (32'(r_cnt) < 32'(r_eff)) begin
                        if (head > r_hi) begin
                            r_hi <= head;
                        end
                        if (head < r_lo) begin
                            r_lo <= head;
                        end
                    end
                    if (32'(r_cnt) == WINDOW_MAX - 1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.window_max <= r_hi;
                        r_out_data.window_min <= r_lo;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
